// ----- rtl/i2cm_pkg.sv -----
`default_nettype none
package i2cm_pkg;

  localparam int unsigned HP_W = 16;
  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd250;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S_FALL   = 5'd1,
    PH_S_CLK    = 5'd2,
    PH_W_HIGH   = 5'd3,
    PH_W_LOW    = 5'd4,
    PH_A_HIGH   = 5'd5,
    PH_A_SAMPLE = 5'd6,
    PH_R_SAMPLE = 5'd7,
    PH_R_HIGH   = 5'd8,
    PH_K_HIGH   = 5'd9,
    PH_K_LOW    = 5'd10,
    PH_P_REL    = 5'd11,
    PH_FINISH   = 5'd12
  } phase_t;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // packed MSB first, so scl lands in bit 0 of the beat
  typedef struct packed {
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/i2cm_core.sv -----
`default_nettype none
module i2cm_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [15:0]             cfg_wdata,
  input  wire logic                    tick,
  input  wire logic [2:0]              cmd,
  input  wire logic [7:0]              tx_byte,
  input  wire logic                    sda_in,
  output i2cm_pkg::res_t               res
);
  import i2cm_pkg::*;

  logic [HP_W-1:0] half_period_r;
  phase_t          phase_r, phase_nxt;
  logic [2:0]      active_cmd_r, active_cmd_nxt;
  logic [3:0]      bit_count_r, bit_count_nxt;
  logic [HP_W-1:0] wait_count_r, wait_count_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            ack_r, ack_nxt;
  logic [7:0]      rx_hold_r, rx_hold_nxt;
  logic            done;
  logic [HP_W-1:0] reload;
  logic [3:0]      bit_inc;
  logic [7:0]      shl;

  // a zero half period behaves as one tick
  assign reload  = (half_period_r == '0) ? '0 : half_period_r - 1'b1;
  assign bit_inc = bit_count_r + 1'b1;
  assign shl     = {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt      = phase_r;
    active_cmd_nxt = active_cmd_r;
    bit_count_nxt  = bit_count_r;
    wait_count_nxt = wait_count_r;
    shift_nxt      = shift_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_nxt        = ack_r;
    rx_hold_nxt    = rx_hold_r;
    done           = 1'b0;
    if (tick) begin
      if (phase_r == PH_IDLE) begin
        if (cmd inside {[CMD_START:CMD_STOP]}) begin
          active_cmd_nxt = cmd;
          bit_count_nxt  = '0;
          wait_count_nxt = reload;
          case (cmd)
            CMD_START: begin
              scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_S_FALL;
            end
            CMD_WRITE: begin
              shift_nxt = tx_byte; sda_nxt = tx_byte[7]; phase_nxt = PH_W_HIGH;
            end
            CMD_STOP: begin
              sda_nxt = 1'b0; scl_nxt = 1'b1; phase_nxt = PH_P_REL;
            end
            default: begin
              shift_nxt = '0; sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_R_SAMPLE;
            end
          endcase
        end
      end else if (wait_count_r != '0) begin
        wait_count_nxt = wait_count_r - 1'b1;
      end else begin
        wait_count_nxt = reload;
        case (phase_r)
          PH_S_FALL: begin sda_nxt = 1'b0; phase_nxt = PH_S_CLK; end
          PH_S_CLK:  begin scl_nxt = 1'b0; phase_nxt = PH_FINISH; end
          PH_W_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_W_LOW; end
          PH_W_LOW: begin
            scl_nxt       = 1'b0;
            shift_nxt     = shl;
            bit_count_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_nxt = shl[7]; phase_nxt = PH_W_HIGH;
            end else begin
              sda_nxt = 1'b1; phase_nxt = PH_A_HIGH;
            end
          end
          PH_A_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_A_SAMPLE; end
          PH_A_SAMPLE: begin
            ack_nxt = ~sda_in; scl_nxt = 1'b0; phase_nxt = PH_FINISH;
          end
          PH_R_SAMPLE: begin
            shift_nxt     = {shift_r[6:0], sda_in};
            scl_nxt       = 1'b0;
            bit_count_nxt = bit_inc;
            phase_nxt     = (bit_inc < BITS_PER_BYTE) ? PH_R_HIGH : PH_K_HIGH;
          end
          PH_R_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_R_SAMPLE; end
          PH_K_HIGH: begin
            sda_nxt   = (active_cmd_r == CMD_READ_NACK);
            scl_nxt   = 1'b1;
            phase_nxt = PH_K_LOW;
          end
          PH_K_LOW:  begin scl_nxt = 1'b0; phase_nxt = PH_FINISH; end
          PH_P_REL: begin
            sda_nxt = 1'b1; phase_nxt = PH_IDLE; wait_count_nxt = wait_count_r; done = 1'b1;
          end
          PH_FINISH: begin
            if (active_cmd_r == CMD_READ_ACK || active_cmd_r == CMD_READ_NACK)
              rx_hold_nxt = shift_r;
            phase_nxt = PH_IDLE; wait_count_nxt = wait_count_r; done = 1'b1;
          end
          default: begin
            // stray phase code: back to idle, no done
            phase_nxt = PH_IDLE; wait_count_nxt = wait_count_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.rx_byte  = rx_hold_nxt;
    res.ack_seen = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      phase_r       <= PH_IDLE;
      active_cmd_r  <= CMD_NONE;
      bit_count_r   <= '0;
      wait_count_r  <= '0;
      shift_r       <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      rx_hold_r     <= '0;
    end else begin
      if (cfg_we) half_period_r <= cfg_wdata;
      phase_r      <= phase_nxt;
      active_cmd_r <= active_cmd_nxt;
      bit_count_r  <= bit_count_nxt;
      wait_count_r <= wait_count_nxt;
      shift_r      <= shift_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_r        <= ack_nxt;
      rx_hold_r    <= rx_hold_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2cm_skid.sv -----
`default_nettype none
module i2cm_skid (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s_valid,
  output logic                s_ready,
  input  wire i2cm_pkg::res_t s_data,
  output logic                m_valid,
  input  wire logic           m_ready,
  output i2cm_pkg::res_t      m_data
);
  import i2cm_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;

  assign s_ready = ~skid_valid_r;
  assign m_valid = out_valid_r;
  assign m_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (s_valid && s_ready) begin
      if (!out_valid_r || m_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_valid_r && m_ready) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      if (!out_valid_r || m_ready) out_r <= s_data;
      else                         skid_r <= s_data;
    end else if (out_valid_r && m_ready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2c_master_byte_engine.sv -----
// A result beat is registered in the output buffer, or in its skid slot while the output stalls.
// Throughput: one input beat per cycle while the skid slot is free; each beat is one tick of the bit timer.
// A two-entry output buffer takes one more input beat while the output stalls.
// Reset (rst_n low, synchronous): idle, SCL/SDA released, half period 250,
// output buffer empty.
`default_nettype none
module i2c_master_byte_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // half_period
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // cmd[2:0], tx_byte[10:3], sda_in[11], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata    // scl, sda, busy, done, rx_byte[11:4], ack[12]
);
  import i2cm_pkg::*;

  logic tick;
  res_t res, res_out;

  assign tick = in_tvalid & in_tready;

  i2cm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .cmd       (in_tdata[2:0]),
    .tx_byte   (in_tdata[10:3]),
    .sda_in    (in_tdata[11]),
    .res       (res)
  );

  i2cm_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (res_out)
  );

  assign out_tdata = {3'b000, res_out};

endmodule
`default_nettype wire

// ----- rtl/i2cm_checker.sv -----
`default_nettype none
module i2cm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // done beat always shows the engine back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done with busy set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // buffer drains: a taken beat frees the skid slot
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |=> in_tready)
    else $error("input still blocked after output taken");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("buffer not empty after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
